@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off during reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Implication checked in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/sbq_pkg.sv @@
// Constants and saturating Q1.31 arithmetic for the shelving biquad filter.
package sbq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [DataW-1:0] sample_t;

  localparam sample_t Q_MAX = 32'sh7FFF_FFFF;
  localparam sample_t Q_MIN = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_B0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_B1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_B2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_A1 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_A2 = 3'd4;

  // Coefficient reset values
  localparam sample_t B0_RESET = 32'sd999576512;
  localparam sample_t B1_RESET = -32'sd1665830784;
  localparam sample_t B2_RESET = 32'sd733657856;
  localparam sample_t A1_RESET = -32'sd818082240;
  localparam sample_t A2_RESET = 32'sd348614944;

  // Q1.31 product rounded toward minus infinity; only -1 * -1 overflows
  function automatic sample_t qmul(input sample_t a, input sample_t b);
    logic signed [2*DataW-1:0] p;
    p = (2*DataW)'(a) * (2*DataW)'(b);
    if (a == Q_MIN && b == Q_MIN) begin
      return Q_MAX;
    end
    return p[2*DataW-2:DataW-1];
  endfunction

  function automatic sample_t sat_add(input sample_t a, input sample_t b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? Q_MIN : Q_MAX;
    end
    return s[DataW-1:0];
  endfunction

  function automatic sample_t sat_sub(input sample_t a, input sample_t b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? Q_MIN : Q_MAX;
    end
    return s[DataW-1:0];
  endfunction

  // Multiply by four with saturation
  function automatic sample_t sat_shl2(input sample_t t);
    if (t[DataW-1:DataW-3] == 3'b000 || t[DataW-1:DataW-3] == 3'b111) begin
      return {t[DataW-3:0], 2'b00};
    end
    return t[DataW-1] ? Q_MIN : Q_MAX;
  endfunction

endpackage

@@ src/shelving_biquad_filter_top.sv @@
// Direct form 1 shelving biquad on Q1.31 samples, one sample per cycle unless stalled.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | sample_in_i, last_sample_i
//  out     | output    | out_valid_o/out_ready_i | sample_out_o
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle sustained unless stalled; an accepted sample passes the
// input register, then the result register, where out_valid_o rises for it.
// The feedback loop y1 -> a1*y1 -> sums -> shift is combinational up to y1_q.
// Reset clears the history, the valid flags and loads the default coefficients.
// A stalled result holds in the output register; the input register still
// drains into it once it frees, so input stalls only when both are full.
module shelving_biquad_filter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [sbq_pkg::DataW-1:0] sample_in_i,
  input  logic                             last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [sbq_pkg::DataW-1:0] sample_out_o,
  input  logic                             cfg_we_i,
  input  logic [sbq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sbq_pkg::DataW-1:0]        cfg_wdata_i
);

  sbq_pkg::sample_t coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  sbq_pkg::sample_t x1_q, x2_q, y1_q, y2_q;
  sbq_pkg::sample_t s1_x_q, y_q, y_d;
  sbq_pkg::sample_t pb0, pb1, pb2, pa1, pa2, sum_b, sum_a, diff;
  logic             s1_valid_q, s1_last_q, out_valid_q;
  logic             s1_adv, in_fire;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= sbq_pkg::B0_RESET;
      coef_b1_q <= sbq_pkg::B1_RESET;
      coef_b2_q <= sbq_pkg::B2_RESET;
      coef_a1_q <= sbq_pkg::A1_RESET;
      coef_a2_q <= sbq_pkg::A2_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbq_pkg::CFG_B0: coef_b0_q <= cfg_wdata_i;
        sbq_pkg::CFG_B1: coef_b1_q <= cfg_wdata_i;
        sbq_pkg::CFG_B2: coef_b2_q <= cfg_wdata_i;
        sbq_pkg::CFG_A1: coef_a1_q <= cfg_wdata_i;
        sbq_pkg::CFG_A2: coef_a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q    <= sample_in_i;
      s1_last_q <= last_sample_i;
    end
  end

  // Filter datapath: five parallel products, saturating sums, shift
  always_comb begin
    pb0   = sbq_pkg::qmul(coef_b0_q, s1_x_q);
    pb1   = sbq_pkg::qmul(coef_b1_q, x1_q);
    pb2   = sbq_pkg::qmul(coef_b2_q, x2_q);
    pa1   = sbq_pkg::qmul(coef_a1_q, y1_q);
    pa2   = sbq_pkg::qmul(coef_a2_q, y2_q);
    sum_b = sbq_pkg::sat_add(sbq_pkg::sat_add(pb0, pb1), pb2);
    sum_a = sbq_pkg::sat_add(pa1, pa2);
    diff  = sbq_pkg::sat_sub(sum_b, sum_a);
    y_d   = sbq_pkg::sat_shl2(diff);
  end

  // History; cleared after the last sample of a block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        x1_q <= '0;
        x2_q <= '0;
        y1_q <= '0;
        y2_q <= '0;
      end else begin
        x2_q <= x1_q;
        x1_q <= s1_x_q;
        y2_q <= y1_q;
        y1_q <= y_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      y_q <= y_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = y_q;

endmodule

@@ src/sbq_checker.sv @@
// Port-level checker for the shelving biquad filter, bound to the top level.
`include "assert_macros.svh"

module sbq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [sbq_pkg::DataW-1:0] sample_out_o
);

  // A stalled result stays valid and unchanged
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(sample_out_o))

  // With the result register empty the input side is never stalled
  `ASSERT_CLK(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // An accepted transaction gives a valid result after passing the input register
  `ASSERT_CLK(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> ##1 out_valid_o)

endmodule

bind shelving_biquad_filter_top sbq_checker u_sbq_checker (.*);

@@ tb/tb_shelving_biquad_filter_top.sv @@
// Self-checking testbench for the shelving biquad filter: directed and random streams.
module tb_shelving_biquad_filter_top;

  localparam int HoldLen       = 200;   // long output hold-off, in cycles
  localparam int WatchdogLimit = 3000;  // cycles without any transaction
  localparam int DrainCycles   = 8;
  localparam int PhaseItems    = 75;
  localparam int NumPhases     = 6;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  sbq_pkg::sample_t                   sample_in = '0;
  logic                               last_sample = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b1;
  sbq_pkg::sample_t                   sample_out;
  logic                               cfg_we = 1'b0;
  logic [sbq_pkg::CfgIdxW-1:0]        cfg_idx = '0;
  logic [sbq_pkg::DataW-1:0]          cfg_wdata = '0;

  // Filter model: coefficients and the x/y delay line
  sbq_pkg::sample_t k_b0 = sbq_pkg::B0_RESET;
  sbq_pkg::sample_t k_b1 = sbq_pkg::B1_RESET;
  sbq_pkg::sample_t k_b2 = sbq_pkg::B2_RESET;
  sbq_pkg::sample_t k_a1 = sbq_pkg::A1_RESET;
  sbq_pkg::sample_t k_a2 = sbq_pkg::A2_RESET;
  sbq_pkg::sample_t x_d1 = '0;
  sbq_pkg::sample_t x_d2 = '0;
  sbq_pkg::sample_t y_d1 = '0;
  sbq_pkg::sample_t y_d2 = '0;

  sbq_pkg::sample_t filtered_q[$];
  sbq_pkg::sample_t want;
  int               fail_cnt = 0;
  int               quiet_cycles = 0;
  bit               tx_idle_en = 1'b0;
  bit               rx_idle_en = 1'b0;
  bit               hold_req = 1'b0;

  shelving_biquad_filter_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_in_i   (sample_in),
    .last_sample_i (last_sample),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sample_out_o  (sample_out),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Saturating Q1.31 helpers
  function automatic sbq_pkg::sample_t sat32(longint v);
    if (v > longint'(sbq_pkg::Q_MAX)) return sbq_pkg::Q_MAX;
    if (v < longint'(sbq_pkg::Q_MIN)) return sbq_pkg::Q_MIN;
    return v[31:0];
  endfunction

  // Product floored to Q1.31; only -1 * -1 leaves the range
  function automatic sbq_pkg::sample_t q31_mul(sbq_pkg::sample_t a, sbq_pkg::sample_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> 31);
  endfunction

  function automatic sbq_pkg::sample_t q31_add(sbq_pkg::sample_t a, sbq_pkg::sample_t b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  // One filter step: returns the output sample and advances the delay line
  function automatic sbq_pkg::sample_t biquad_step(sbq_pkg::sample_t x, bit eob);
    sbq_pkg::sample_t ff, fb, t, y;
    ff = q31_add(q31_add(q31_mul(k_b0, x), q31_mul(k_b1, x_d1)), q31_mul(k_b2, x_d2));
    fb = q31_add(q31_mul(k_a1, y_d1), q31_mul(k_a2, y_d2));
    t  = sat32(longint'(ff) - longint'(fb));
    y  = sat32(longint'(t) * 4);
    if (eob) begin
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
    end else begin
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = y;
    end
    return y;
  endfunction

  // Idle lengths: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic sbq_pkg::sample_t pick_sample(int style);
    sbq_pkg::sample_t s;
    s = $urandom;
    case (style)
      0: return sbq_pkg::sample_t'(int'($urandom_range(0, 131071)) - 65536);
      1: return s;
      2: begin
        case ($urandom_range(0, 3))
          0: return sbq_pkg::Q_MAX;
          1: return sbq_pkg::Q_MIN;
          2: return '0;
          default: return s;
        endcase
      end
      default: return s >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Coefficient per setting: reset value, mild random, full random, extremes
  function automatic sbq_pkg::sample_t pick_coef(int mode, sbq_pkg::sample_t dflt);
    sbq_pkg::sample_t s;
    s = $urandom;
    case (mode)
      0: return dflt;
      1: return s >>> 2;
      2: return s;
      default: begin
        case ($urandom_range(0, 3))
          0: return sbq_pkg::Q_MAX;
          1: return sbq_pkg::Q_MIN;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Offer one sample; prediction is made at the accepting edge
  task automatic send_sample(sbq_pkg::sample_t x, bit eob);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= x;
    last_sample <= eob;
    do @(posedge clk); while (!in_ready);
    filtered_q.push_back(biquad_step(x, eob));
  endtask

  // Drop valid and wait until every output has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_coef(logic [sbq_pkg::CfgIdxW-1:0] idx, sbq_pkg::sample_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sbq_pkg::CFG_B0: k_b0 = val;
      sbq_pkg::CFG_B1: k_b1 = val;
      sbq_pkg::CFG_B2: k_b2 = val;
      sbq_pkg::CFG_A1: k_a1 = val;
      sbq_pkg::CFG_A2: k_a2 = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(sbq_pkg::sample_t b0, sbq_pkg::sample_t b1,
                           sbq_pkg::sample_t b2, sbq_pkg::sample_t a1,
                           sbq_pkg::sample_t a2);
    write_coef(sbq_pkg::CFG_B0, b0);
    write_coef(sbq_pkg::CFG_B1, b1);
    write_coef(sbq_pkg::CFG_B2, b2);
    write_coef(sbq_pkg::CFG_A1, a1);
    write_coef(sbq_pkg::CFG_A2, a2);
  endtask

  // Reset coefficients: impulse response, block end clearing history
  task automatic test_default_response();
    send_sample(sbq_pkg::Q_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample(sbq_pkg::Q_MIN, 1'b0);
    send_sample(32'sd12345, 1'b1);
    send_sample('0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    wait_idle();
  endtask

  // Product, sum, difference and shift saturation
  task automatic test_saturation();
    write_all(sbq_pkg::Q_MIN, sbq_pkg::Q_MIN, sbq_pkg::Q_MIN, sbq_pkg::Q_MIN,
              sbq_pkg::Q_MIN);
    send_sample(sbq_pkg::Q_MIN, 1'b0);
    send_sample(sbq_pkg::Q_MIN, 1'b0);
    send_sample(sbq_pkg::Q_MIN, 1'b0);
    send_sample(sbq_pkg::Q_MAX, 1'b1);
    wait_idle();
    write_all(sbq_pkg::Q_MAX, sbq_pkg::Q_MAX, sbq_pkg::Q_MAX, sbq_pkg::Q_MAX,
              sbq_pkg::Q_MAX);
    send_sample(sbq_pkg::Q_MAX, 1'b0);
    send_sample(sbq_pkg::Q_MAX, 1'b0);
    send_sample(sbq_pkg::Q_MIN, 1'b0);
    send_sample(sbq_pkg::Q_MIN, 1'b1);
    wait_idle();
    // large gain, feedback of opposite sign
    write_all(sbq_pkg::Q_MAX, '0, sbq_pkg::Q_MIN, sbq_pkg::Q_MIN, sbq_pkg::Q_MAX);
    send_sample(32'sh2000_0000, 1'b0);
    send_sample(32'sh1FFF_FFFF, 1'b0);
    send_sample(-32'sh2000_0000, 1'b0);
    send_sample(32'sh0000_0001, 1'b1);
    wait_idle();
  endtask

  // Writes to indexes past the last register leave the coefficients alone
  task automatic test_unused_index();
    for (int i = int'(sbq_pkg::CFG_A2) + 1; i < (1 << sbq_pkg::CfgIdxW); i++) begin
      write_coef(i[sbq_pkg::CfgIdxW-1:0], $urandom);
    end
    send_sample(sbq_pkg::Q_MAX, 1'b0);
    send_sample(sbq_pkg::Q_MIN, 1'b0);
    send_sample(32'sh5555_AAAA, 1'b1);
    wait_idle();
  endtask

  // Output held off for a long stretch while input keeps coming
  task automatic test_output_stall();
    write_all(sbq_pkg::B0_RESET, sbq_pkg::B1_RESET, sbq_pkg::B2_RESET,
              sbq_pkg::A1_RESET, sbq_pkg::A2_RESET);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_sample(pick_sample(i % 4), $urandom_range(0, 7) == 0);
    end
    wait_idle();
  endtask

  // Random blocks of samples, closed by a block end unless the phase runs out, over several settings
  task automatic test_random_stream();
    int sent;
    int blen;
    int style;
    int mode;
    for (int p = 0; p < NumPhases; p++) begin
      mode = (p == 0) ? 0 : $urandom_range(0, 3);
      if (p == NumPhases - 1) mode = 3;
      write_all(pick_coef(mode, sbq_pkg::B0_RESET), pick_coef(mode, sbq_pkg::B1_RESET),
                pick_coef(mode, sbq_pkg::B2_RESET), pick_coef(mode, sbq_pkg::A1_RESET),
                pick_coef(mode, sbq_pkg::A2_RESET));
      tx_idle_en = (p % 3 != 0);
      rx_idle_en = (p % 2 == 0);
      sent = 0;
      while (sent < PhaseItems) begin
        blen  = $urandom_range(1, 48);
        style = $urandom_range(0, 3);
        for (int i = 0; i < blen && sent < PhaseItems; i++) begin
          // mostly proper blocks, occasionally a stray block end
          send_sample(pick_sample(style),
                      (i == blen - 1) || ($urandom_range(0, 63) == 0));
          sent++;
        end
      end
      wait_idle();
    end
  endtask

  // Output side: random hold-offs, plus one long requested hold
  initial begin : rx_driver
    int n;
    forever begin
      @(negedge clk);
      n = 0;
      if (hold_req) begin
        n = HoldLen;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        n = idle_len();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("** shelving_biquad_filter_top: FAILED **");
        $finish;
      end else if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("sample_out: no transaction pending, got %0d", sample_out);
          fail_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (sample_out !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, sample_out);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_response();
    test_saturation();
    test_unused_index();
    test_output_stall();
    test_random_stream();
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("** shelving_biquad_filter_top: PASSED **");
    end else begin
      $display("** shelving_biquad_filter_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/sbq_pkg.sv
src/shelving_biquad_filter_top.sv
src/sbq_checker.sv
tb/tb_shelving_biquad_filter_top.sv
